// ===== hw/rtl/ledfe_pkg.sv =====
// shared types and constants for the addressable led frame encoder
package ledfe_pkg;

   // op codes on the request channel
   localparam logic OP_FILL = 1'b0;
   localparam logic OP_SLOT = 1'b1;

   // configuration register indexes
   localparam logic CSR_DUTY_ONE  = 1'b0;
   localparam logic CSR_DUTY_ZERO = 1'b1;

   // register reset values
   localparam logic [7:0] DUTY_ONE_RESET  = 8'd60;
   localparam logic [7:0] DUTY_ZERO_RESET = 8'd30;

   // each pixel is 24 bit slots, green red blue, msb first
   localparam logic [4:0] BIT_LAST = 5'd23;

   // kind of work handed from front to back
   typedef enum logic {
      CMD_FILL,
      CMD_SLOT
   } cmd_kind_type;

   // one queued item
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   head;
      logic [7:0]   tail;
      logic [23:0]  colour;
   } cmd_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_READ,
      ST_EMIT
   } back_state_type;

endpackage

// ===== hw/rtl/addressable_led_frame_encoder.sv =====
// Top level of the addressable led frame encoder.
// A slot item is dequeued by the back end when idle, its pixel is read from memory in the read state
// and its duty is emitted as a registered strobe; a fill item holds the back end while it writes its range.
// The back end takes the next item only once back in idle, but the queue can accept items meanwhile.
// Reset: synchronous, active high; clears queue, slot position and written flags, and restores duty registers.
// The result strobe lasts one cycle; the receiver cannot stall it.
module addressable_led_frame_encoder
   import ledfe_pkg::*;
#(
   parameter int PIXEL_COUNT  = 32,
   parameter int RESET_PIXELS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_op,
   input  logic [7:0] req_head,
   input  logic [7:0] req_tail,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   output logic [7:0] rsp_duty,
   output logic       rsp_frame_end,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic [7:0] duty_one_val_ff;
   logic [7:0] duty_zero_val_ff;
   logic       push;
   cmd_type    push_cmd;
   logic       pop;
   logic       full;
   logic       empty;
   cmd_type    head_cmd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_one_val_ff  <= DUTY_ONE_RESET;
         duty_zero_val_ff <= DUTY_ZERO_RESET;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_DUTY_ONE:  duty_one_val_ff  <= csr_wdata;
               CSR_DUTY_ZERO: duty_zero_val_ff <= csr_wdata;
            endcase
         end
      end
   end

   assign busy = full;

   ledfe_front #(
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_front (
      .start      (start),
      .queue_full (full),
      .req_op     (req_op),
      .req_head   (req_head),
      .req_tail   (req_tail),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   ledfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head_cmd (head_cmd)
   );

   ledfe_back #(
      .PIXEL_COUNT  (PIXEL_COUNT),
      .RESET_PIXELS (RESET_PIXELS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (empty),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .duty_one      (duty_one_val_ff),
      .duty_zero     (duty_zero_val_ff),
      .rsp_valid     (rsp_valid),
      .rsp_duty      (rsp_duty),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== hw/rtl/ledfe_front.sv =====
// front end: accepts request items and classifies them for the queue
module ledfe_front
   import ledfe_pkg::*;
#(
   parameter int PIXEL_COUNT = 32
) (
   input  logic       start,
   input  logic       queue_full,
   input  logic       req_op,
   input  logic [7:0] req_head,
   input  logic [7:0] req_tail,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       push,
   output cmd_type    push_cmd
);

   logic accept;
   logic fill_empty;

   // an item is taken whenever start is high and the queue has room
   assign accept = start && !queue_full;

   // a fill whose range is empty or starts beyond the chain writes nothing
   assign fill_empty = (req_head > req_tail) || (req_head >= 8'(PIXEL_COUNT));

   // classify and forward, dropping fills that do nothing
   always_comb begin
      push_cmd.kind   = (req_op == OP_SLOT) ? CMD_SLOT : CMD_FILL;
      push_cmd.head   = req_head;
      push_cmd.tail   = req_tail;
      push_cmd.colour = {req_green, req_red, req_blue};
      push            = accept && ((req_op == OP_SLOT) || !fill_empty);
   end

endmodule

// ===== hw/rtl/ledfe_queue.sv =====
// two entry command queue between front and back
module ledfe_queue
   import ledfe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head_cmd
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/ledfe_back.sv =====
// back end: pixel store, fill walker and frame slot serialiser
module ledfe_back
   import ledfe_pkg::*;
#(
   parameter int PIXEL_COUNT  = 32,
   parameter int RESET_PIXELS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  cmd_type    head_cmd,
   output logic       pop,
   input  logic [7:0] duty_one,
   input  logic [7:0] duty_zero,
   output logic       rsp_valid,
   output logic [7:0] rsp_duty,
   output logic       rsp_frame_end
);

   localparam int FRAME_PIX = PIXEL_COUNT + RESET_PIXELS;
   localparam int PW        = $clog2(FRAME_PIX);
   localparam int AW        = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   back_state_type   state_ff, state_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       tail_ff, tail_in;
   logic [23:0]      colour_ff, colour_in;
   logic [PW-1:0]    pix_ff, pix_in;
   logic [4:0]       bit_ff, bit_in;
   logic             valid_ff, valid_in;
   logic [7:0]       duty_ff, duty_in;
   logic             frame_end_ff, frame_end_in;

   logic [23:0]      pixel_mem [PIXEL_COUNT];
   logic [PIXEL_COUNT-1:0] written_ff;
   logic [23:0]      rd_colour_ff;
   logic             rd_written_ff;
   logic             mem_we;
   logic             mem_re;
   logic             in_pixels;
   logic             slot_bit;
   logic             fill_done;

   assign in_pixels = (pix_ff < PW'(PIXEL_COUNT));
   assign slot_bit  = rd_colour_ff[BIT_LAST - bit_ff];
   assign fill_done = (id_ff == tail_ff) || (id_ff == 8'(PIXEL_COUNT - 1));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      tail_in      = tail_ff;
      colour_in    = colour_ff;
      pix_in       = pix_ff;
      bit_in       = bit_ff;
      valid_in     = 1'b0;
      duty_in      = duty_ff;
      frame_end_in = frame_end_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               id_in     = head_cmd.head;
               tail_in   = head_cmd.tail;
               colour_in = head_cmd.colour;
               state_in  = (head_cmd.kind == CMD_FILL) ? ST_FILL : ST_READ;
            end
         end
         ST_FILL: begin
            // one pixel written per cycle
            mem_we = 1'b1;
            id_in  = id_ff + 8'd1;
            if (fill_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            mem_re   = in_pixels;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            valid_in     = 1'b1;
            frame_end_in = (pix_ff == PW'(FRAME_PIX - 1)) && (bit_ff == BIT_LAST);
            if (in_pixels && rd_written_ff) begin
               duty_in = slot_bit ? duty_one : duty_zero;
            end else begin
               duty_in = 8'd0;
            end
            // advance to the next slot of the frame
            if (bit_ff == BIT_LAST) begin
               bit_in = 5'd0;
               pix_in = (pix_ff == PW'(FRAME_PIX - 1)) ? '0 : pix_ff + PW'(1);
            end else begin
               bit_in = bit_ff + 5'd1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pix_ff   <= '0;
         bit_ff   <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pix_ff   <= pix_in;
         bit_ff   <= bit_in;
         valid_ff <= valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      tail_ff      <= tail_in;
      colour_ff    <= colour_in;
      duty_ff      <= duty_in;
      frame_end_ff <= frame_end_in;
   end

   // pixel written flags
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (mem_we) begin
         written_ff[id_ff[AW-1:0]] <= 1'b1;
      end
   end

   // pixel colour memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[id_ff[AW-1:0]] <= colour_ff;
      end
      if (mem_re) begin
         rd_colour_ff  <= pixel_mem[pix_ff[AW-1:0]];
         rd_written_ff <= written_ff[pix_ff[AW-1:0]];
      end else begin
         rd_written_ff <= 1'b0;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_duty      = duty_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// ===== hw/rtl/ledfe_checker.sv =====
// port level checks for the addressable led frame encoder, with its bind
module ledfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_duty,
   input logic       rsp_frame_end
);

   // nothing comes out in the first cycles after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("result or busy right after reset");

   a_quiet_two_after_reset: assert property (@(posedge clock)
      $past(reset, 2) |-> !rsp_valid)
      else $error("result too soon after reset");

   // the last reset slot always carries zero duty
   a_frame_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_duty == 8'd0)
      else $error("frame end slot with non zero duty");

   // a slot never comes out directly after another
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back result strobes");

   // under busy with start low, a strobe never follows another while busy holds
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      busy && !start |=> !rsp_valid || !busy || $past(rsp_valid) == 1'b0)
      else $error("unexpected strobe under busy");

endmodule

bind addressable_led_frame_encoder ledfe_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_duty      (rsp_duty),
   .rsp_frame_end (rsp_frame_end)
);

// ===== test/testbench.sv =====
// self-checking testbench for the addressable led frame encoder
module testbench;
   import ledfe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIXEL_COUNT    = 32;
   localparam int RESET_PIXELS   = 10;
   localparam int BITS_PER_PIXEL = 24;
   localparam int FRAME_SLOTS    = (PIXEL_COUNT + RESET_PIXELS) * BITS_PER_PIXEL;

   // one expected duty word
   typedef struct packed {
      logic [7:0] duty;
      logic       frame_end;
   } slot_word_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_op;
   logic [7:0] req_head;
   logic [7:0] req_tail;
   logic [7:0] req_red;
   logic [7:0] req_green;
   logic [7:0] req_blue;
   logic       rsp_valid;
   logic [7:0] rsp_duty;
   logic       rsp_frame_end;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   // predicted pixel store, frame position and duty registers
   logic [23:0] colour_store [PIXEL_COUNT];
   logic        written_mask [PIXEL_COUNT];
   int          frame_pos;
   logic [7:0]  duty_one_reg;
   logic [7:0]  duty_zero_reg;

   slot_word_type pending_slots [$];
   int            error_count;
   bit            idle_enable;

   addressable_led_frame_encoder #(
      .PIXEL_COUNT  (PIXEL_COUNT),
      .RESET_PIXELS (RESET_PIXELS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_head      (req_head),
      .req_tail      (req_tail),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_duty      (rsp_duty),
      .rsp_frame_end (rsp_frame_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // write a colour over a pixel range, skipping ids past the chain
   task automatic model_fill_range(logic [7:0] head, logic [7:0] tail, logic [23:0] colour);
      int id;
      for (id = head; id <= tail; id++) begin
         if (id < PIXEL_COUNT) begin
            colour_store[id] = colour;
            written_mask[id] = 1'b1;
         end
      end
   endtask

   // duty word for the current frame position, then advance it
   function automatic slot_word_type next_slot_word();
      slot_word_type word;
      int            pix;
      int            bit_idx;
      if (frame_pos >= FRAME_SLOTS)
         frame_pos = 0;
      pix     = frame_pos / BITS_PER_PIXEL;
      bit_idx = frame_pos % BITS_PER_PIXEL;
      if (pix >= PIXEL_COUNT || !written_mask[pix])
         word.duty = 8'd0;
      else
         word.duty = colour_store[pix][23 - bit_idx] ? duty_one_reg : duty_zero_reg;
      word.frame_end = (frame_pos == FRAME_SLOTS - 1);
      frame_pos = (frame_pos + 1 >= FRAME_SLOTS) ? 0 : frame_pos + 1;
      return word;
   endfunction

   // drive one item, wait for acceptance, then maybe idle for a burst
   task automatic send_item(logic op, logic [7:0] head, logic [7:0] tail,
                            logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      req_op    = op;
      req_head  = head;
      req_tail  = tail;
      req_red   = red;
      req_green = green;
      req_blue  = blue;
      start     = 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (op == OP_FILL)
         model_fill_range(head, tail, {green, red, blue});
      else
         pending_slots.push_back(next_slot_word());
      @(negedge clock);
      start = 1'b0;
      if (idle_enable && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   task automatic send_slot();
      send_item(OP_SLOT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
   endtask

   // wait until every expected item has come back
   task automatic wait_drained();
      while (pending_slots.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // register write, only once the back end has gone quiet
   task automatic write_duty(logic index, logic [7:0] value);
      wait_drained();
      repeat (300) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      if (index == CSR_DUTY_ONE)
         duty_one_reg = value;
      else
         duty_zero_reg = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // frame straight out of reset: nothing written, all zero duty
   task automatic test_unwritten_slots();
      repeat (4) send_slot();
   endtask

   // fills at the edges of the id range, then read back a pixel
   task automatic test_fill_special_cases();
      // head above tail writes nothing
      send_item(OP_FILL, 8'd5, 8'd3, 8'hFF, 8'hFF, 8'hFF);
      // range running past the chain up to the last id
      send_item(OP_FILL, 8'd30, 8'd255, 8'h0F, 8'hF0, 8'h3C);
      // ids wholly beyond the chain
      send_item(OP_FILL, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF);
      send_item(OP_FILL, 8'd32, 8'd40, 8'hFF, 8'hFF, 8'hFF);
      // single pixel at id zero with mixed bits
      send_item(OP_FILL, 8'd0, 8'd0, 8'h55, 8'hAA, 8'hF0);
      send_item(OP_FILL, 8'd31, 8'd31, 8'h00, 8'h00, 8'h00);
      repeat (16) send_slot();
   endtask

   // mostly slot items with fills of small ranges, some wild ranges
   task automatic test_random_traffic(int count);
      logic [7:0] head;
      logic [7:0] tail;
      int         kind;
      repeat (count - 1) begin
         if ($urandom_range(0, 99) < 85) begin
            send_slot();
         end else begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
               head = 8'($urandom);
               tail = 8'($urandom);
            end else if (kind == 1) begin
               head = 8'($urandom_range(1, PIXEL_COUNT + 4));
               tail = 8'(head - $urandom_range(1, head));
            end else begin
               head = 8'($urandom_range(0, PIXEL_COUNT + 4));
               tail = (head + $urandom_range(0, 6) > 255) ? 8'd255
                                                          : 8'(head + $urandom_range(0, 6));
            end
            send_item(OP_FILL, head, tail, 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
      // a trailing slot so the drain covers every queued fill
      send_slot();
   endtask

   // duty registers at their extremes and in between, with traffic at each
   task automatic test_duty_settings();
      write_duty(CSR_DUTY_ONE, 8'd255);
      write_duty(CSR_DUTY_ZERO, 8'd0);
      test_random_traffic(375);
      write_duty(CSR_DUTY_ONE, 8'd0);
      write_duty(CSR_DUTY_ZERO, 8'd255);
      test_random_traffic(375);
      write_duty(CSR_DUTY_ONE, 8'($urandom));
      write_duty(CSR_DUTY_ZERO, 8'($urandom));
      test_random_traffic(375);
      write_duty(CSR_DUTY_ONE, 8'd128);
      write_duty(CSR_DUTY_ZERO, 8'd128);
      idle_enable = 1'b0;
      test_random_traffic(375);
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin : check_result
      slot_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_slots.size() == 0) begin
            $display("%0t: unexpected item, duty %0d frame_end %0d",
                     $realtime, rsp_duty, rsp_frame_end);
            error_count++;
         end else begin
            want = pending_slots.pop_front();
            if (rsp_duty !== want.duty) begin
               $display("%0t: duty expected %0d actual %0d", $realtime, want.duty, rsp_duty);
               error_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $display("%0t: frame_end expected %0d actual %0d",
                        $realtime, want.frame_end, rsp_frame_end);
               error_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      int i;
      reset       = 1'b1;
      start       = 1'b0;
      req_op      = OP_FILL;
      req_head    = 8'd0;
      req_tail    = 8'd0;
      req_red     = 8'd0;
      req_green   = 8'd0;
      req_blue    = 8'd0;
      csr_we      = 1'b0;
      csr_index   = CSR_DUTY_ONE;
      csr_wdata   = 8'd0;
      error_count = 0;
      idle_enable = 1'b1;
      frame_pos   = 0;
      duty_one_reg  = DUTY_ONE_RESET;
      duty_zero_reg = DUTY_ZERO_RESET;
      for (i = 0; i < PIXEL_COUNT; i++) begin
         colour_store[i] = 24'd0;
         written_mask[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_unwritten_slots();
      test_fill_special_cases();
      test_duty_settings();

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("addressable_led_frame_encoder verification clean");
      else
         $display("addressable_led_frame_encoder verification failed");
      $finish;
   end

   // run limit
   initial begin
      #5ms;
      $display("addressable_led_frame_encoder verification failed");
      $finish;
   end

endmodule
